FILE: sv/pipas_pkg.sv
`default_nettype none

package pipas_pkg;

    // Result transfer layout, lowest bit first
    localparam int OUT_DATA_WIDTH = 8;
    localparam int OUT_INSIDE_BIT = 0;
    localparam int OUT_VERTEX_BIT = 1;

    // Number of distinct CORDIC steps held in the arctangent table
    localparam int ATAN_STEPS = 32;

    // atan(2^-k) in units of 2^-32 turn, rounded to nearest
    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/point_in_polygon_angle_sum.sv
// Point-in-polygon test by angle summation.
// Input stream: one polygon vertex per transfer. tdata carries vertex_x,
// vertex_y, point_x, point_y (COORD_WIDTH bits each, lowest field first);
// tlast marks the final vertex of the polygon.
// Output stream: one transfer per polygon, issued after the last vertex.
// tdata bit 0 is inside_res, bit 1 is on_vertex, the rest are zero.
// Each vertex runs through one shared CORDIC vectoring unit, one iteration
// per cycle. A vertex holds the input through the prepare step, the CORDIC
// iterations and the accumulate step (the CORDIC pass is skipped when the
// vertex coincides with the point); the last vertex then goes on to the
// closing turn and the parity test, which writes the output register.
// The result sits in an output register; the next polygon may start while
// it waits. If the receiver stalls, a second result holds in the final
// step until the register frees, and the input stays not ready meanwhile.
// Reset (synchronous, active low) clears the polygon state and drops any
// pending result.
`default_nettype none

module point_in_polygon_angle_sum
    import pipas_pkg::*;
#(
    parameter int COORD_WIDTH       = 32,
    parameter int ANGLE_BITS        = 20,
    parameter int CORDIC_ITERATIONS = 20,
    localparam int IN_W = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // vertex_x, vertex_y, point_x, point_y, from the lowest bit up
    input  wire logic [IN_W-1:0]           i_s_axis_tdata,
    input  wire logic                      i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    // inside_res, on_vertex, zero padding, from the lowest bit up
    output logic [OUT_DATA_WIDTH-1:0]      o_m_axis_tdata
);

    localparam int W     = COORD_WIDTH + 4;
    localparam int A     = ANGLE_BITS;
    localparam int IW    = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
    localparam int SH    = 32 - A;
    localparam int SHM1  = (SH > 0) ? SH - 1 : 0;
    localparam logic [32:0]   RND      = (SH > 0) ? (33'd1 << SHM1) : 33'd0;
    localparam logic [A-1:0]  HALF     = {1'b1, {(A - 1){1'b0}}};
    localparam logic [33:0]   FULL     = 34'd1 << A;
    localparam logic [33:0]   MOD_MASK = (34'd1 << (A + 1)) - 34'd1;
    localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_ITERATIONS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PREP = 6'b000010,
        S_ITER = 6'b000100,
        S_ACC  = 6'b001000,
        S_CLOSE = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic signed [W-1:0]   r_x, n_x;
    logic signed [W-1:0]   r_y, n_y;
    logic [31:0]           r_z, n_z;
    logic [IW-1:0]         r_iter, n_iter;
    logic                  r_zero, n_zero;
    logic                  r_last, n_last;
    logic [A-1:0]          r_first, n_first;
    logic [A-1:0]          r_prev, n_prev;
    logic [31:0]           r_acc, n_acc;
    logic                  r_coinc, n_coinc;
    logic                  r_started, n_started;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_out, n_out;

    // Signed turn between two directions, wrapped to (-1/2, 1/2] turn
    function automatic logic [31:0] turn_of(input logic [A-1:0] from,
                                            input logic [A-1:0] to);
        logic [A-1:0] d;
        d = to - from;
        if (d > HALF) begin
            return 32'($signed(d));
        end
        return 32'(d);
    endfunction

    logic signed [W-1:0] vx_s, vy_s, px_s, py_s;
    logic signed [W-1:0] xs, ys;
    logic [32:0]         z_rnd;
    logic [A-1:0]        dir;
    logic [A-1:0]        turn_to;
    logic [31:0]         turn;
    logic [32:0]         mag;
    logic [33:0]         wind;
    logic                in_poly;

    // Unpack and sign-extend the coordinates
    assign vx_s = W'($signed(i_s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH]));
    assign vy_s = W'($signed(i_s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH]));
    assign px_s = W'($signed(i_s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]));
    assign py_s = W'($signed(i_s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH]));

    // Shared CORDIC shifter
    assign xs = r_x >>> r_iter;
    assign ys = r_y >>> r_iter;

    // Round the CORDIC angle to ANGLE_BITS, ties up
    assign z_rnd = {1'b0, r_z} + RND;
    assign dir   = r_zero ? '0 : z_rnd[31:SH];

    // Shared turn unit: step turn, then closing turn
    assign turn_to = (r_state == S_CLOSE) ? r_first : dir;
    assign turn    = turn_of(r_prev, turn_to);

    // Winding parity test on the accumulated turns
    assign mag     = r_acc[31] ? (33'd0 - {1'b0, r_acc}) : {1'b0, r_acc};
    assign wind    = (34'(mag) + (FULL >> 1)) & MOD_MASK;
    assign in_poly = (wind > FULL) || r_coinc;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_WIDTH - 2){1'b0}}, r_out};

    // Sequencer and datapath next state
    always_comb begin
        n_state     = r_state;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_iter      = r_iter;
        n_zero      = r_zero;
        n_last      = r_last;
        n_first     = r_first;
        n_prev      = r_prev;
        n_acc       = r_acc;
        n_coinc     = r_coinc;
        n_started   = r_started;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // drop the result once transferred
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_x     = vx_s - px_s;
                    n_y     = vy_s - py_s;
                    n_last  = i_s_axis_tlast;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // fold the left half-plane by a half turn
                n_zero = (r_x == '0) && (r_y == '0);
                n_iter = '0;
                if (r_x < 0) begin
                    n_x = -r_x;
                    n_y = -r_y;
                    n_z = 32'h80000000;
                end else begin
                    n_z = 32'h00000000;
                end
                n_state = n_zero ? S_ACC : S_ITER;
            end
            S_ITER: begin
                // rotate toward y = 0
                if (!r_y[W-1]) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + atan_turn(5'(r_iter));
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - atan_turn(5'(r_iter));
                end
                n_iter = r_iter + 1'b1;
                if (r_iter == ITER_LAST) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (!r_started) begin
                    n_first   = dir;
                    n_acc     = '0;
                    n_coinc   = r_zero;
                    n_started = 1'b1;
                end else begin
                    n_acc   = r_acc + turn;
                    n_coinc = r_coinc | r_zero;
                end
                n_prev  = dir;
                n_state = r_last ? S_CLOSE : S_IDLE;
            end
            S_CLOSE: begin
                n_acc   = r_acc + turn;
                n_state = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out[OUT_INSIDE_BIT] = in_poly;
                    n_out[OUT_VERTEX_BIT] = r_coinc;
                    n_out_valid = 1'b1;
                    n_acc       = '0;
                    n_coinc     = 1'b0;
                    n_started   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and polygon state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_first     <= '0;
            r_prev      <= '0;
            r_acc       <= '0;
            r_coinc     <= 1'b0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_prev      <= n_prev;
            r_acc       <= n_acc;
            r_coinc     <= n_coinc;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_iter <= n_iter;
        r_zero <= n_zero;
        r_last <= n_last;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

FILE: sv/pipas_check.sv
`default_nettype none

module pipas_check
    import pipas_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_axis_tvalid,
    input wire logic                      o_s_axis_tready,
    input wire logic                      o_m_axis_tvalid,
    input wire logic                      i_m_axis_tready,
    input wire logic [OUT_DATA_WIDTH-1:0] o_m_axis_tdata
);

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // A point on a vertex is always inside
    a_vertex_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[OUT_VERTEX_BIT] |-> o_m_axis_tdata[OUT_INSIDE_BIT])
        else $error("on_vertex without inside_res");

    // A vertex transfer keeps the input busy, so it is not ready in the cycle after
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after a transfer");

endmodule

bind point_in_polygon_angle_sum pipas_check u_pipas_check (.*);

`default_nettype wire
